@@ sv/log2_latency_histogram_macros.svh @@
`ifndef LOG2_LATENCY_HISTOGRAM_MACROS_SVH
`define LOG2_LATENCY_HISTOGRAM_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define LLH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define LLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/llh_pkg.sv @@
package llh_pkg;

  // Default configuration
  localparam int BUCKETS_DEF     = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int LAT_W = 64;
  localparam int P_W   = 17;
  localparam int EST_W = 31;
  localparam int RUN_W = 64;

  // Percentile 1.0 in Q1.16
  localparam logic [P_W-1:0] Q16_ONE = 17'h10000;

  // Func codes
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rec_rd;
    logic rec_wr;
    logic mul_step;
    logic rank_ld;
    logic scan_go;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_last;
    logic scan_hit;
    logic scan_end;
  } sts_t;

endpackage

@@ sv/llh_dp.sv @@
`include "log2_latency_histogram_macros.svh"

module llh_dp #(
  parameter int BUCKETS     = llh_pkg::BUCKETS_DEF,
  parameter int COUNT_WIDTH = llh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  llh_pkg::cmd_t             cmd,
  output llh_pkg::sts_t             sts,
  input  logic [llh_pkg::LAT_W-1:0] in_latency_ns,
  input  logic [llh_pkg::P_W-1:0]   in_percentile_q16,
  output logic                      out_valid,
  output logic [llh_pkg::EST_W-1:0] out_latency_estimate
);
  import llh_pkg::*;

  localparam int BW  = $clog2(BUCKETS);
  localparam int NCH = (COUNT_WIDTH + 15) / 16;
  localparam int TW  = NCH * 16;
  localparam int AW  = TW + P_W;
  localparam int MCW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int NLC = LAT_W / 16;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [BW-1:0]          LAST_IDX = BW'(BUCKETS - 1);

  // Lower bucket edge 2^sh, zero when it falls outside the estimate width
  function automatic logic [EST_W-1:0] est_pow(input logic [6:0] sh);
    logic [EST_W-1:0] v;
    v = '0;
    if (sh < 7'(EST_W)) begin
      v = EST_W'(1) << sh;
    end
    return v;
  endfunction

  // Bucket store
  logic [COUNT_WIDTH-1:0] mem [BUCKETS];
  logic [BUCKETS-1:0]     vld_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   rd_vbit_r;
  logic                   rd_en;
  logic [BW-1:0]          rd_addr;
  logic [COUNT_WIDTH-1:0] rd_cnt;

  // Record path
  logic [NLC-1:0]   nz_r;
  logic [4:0]       lw_r   [NLC];
  logic [4:0]       lw_nxt [NLC];
  logic [6:0]       wid;
  logic [BW-1:0]    bucket_nxt;
  logic [BW-1:0]    bucket_r;
  logic [COUNT_WIDTH-1:0] total_r;

  // Query path
  logic [P_W-1:0]         p_r;
  logic [TW-1:0]          tot_sh_r;
  logic [AW-1:0]          acc_r;
  logic [MCW-1:0]         mcnt_r;
  logic [2*16:0]          prod;
  logic [AW:0]            rsum;
  logic [COUNT_WIDTH-1:0] rank_r;
  logic [BW-1:0]          scan_idx_r;
  logic                   issue_done_r;
  logic                   scan_iss;
  logic                   rdq_vld_r;
  logic [BW-1:0]          rdq_idx_r;
  logic [RUN_W-1:0]       run_r;
  logic [RUN_W:0]         run_sum;
  logic [RUN_W-1:0]       run_nxt;
  logic [EST_W-1:0]       est_hit;
  logic [EST_W-1:0]       est_dflt;
  logic                   out_valid_r;
  logic [EST_W-1:0]       out_est_r;

  // Find the bit width inside each 16-bit slice of the latency
  always_comb begin
    for (int k = 0; k < NLC; k++) begin
      lw_nxt[k] = '0;
      for (int b = 0; b < 16; b++) begin
        if (in_latency_ns[16*k + b]) begin
          lw_nxt[k] = 5'(b + 1);
        end
      end
    end
  end

  // Combine the slices: the highest nonzero slice sets the width, capped at the last bucket
  always_comb begin
    wid = '0;
    for (int k = 0; k < NLC; k++) begin
      if (nz_r[k]) begin
        wid = 7'(16 * k) + 7'(lw_r[k]);
      end
    end
    bucket_nxt = (wid > 7'(BUCKETS - 1)) ? LAST_IDX : BW'(wid);
  end

  // Memory read port select
  assign scan_iss = cmd.scan_go && !issue_done_r;
  assign rd_en    = cmd.rec_rd || scan_iss;
  assign rd_addr  = cmd.rec_rd ? bucket_nxt : scan_idx_r;
  assign rd_cnt   = rd_vbit_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.rec_wr) begin
      mem[bucket_r] <= (rd_cnt == CNT_MAX) ? CNT_MAX : rd_cnt + 1'b1;
    end
  end

  // Valid bits and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      rd_vbit_r   <= 1'b0;
      total_r     <= '0;
      rdq_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vbit_r <= vld_r[rd_addr];
      end
      if (cmd.rec_wr) begin
        vld_r[bucket_r] <= 1'b1;
        total_r         <= (total_r == CNT_MAX) ? CNT_MAX : total_r + 1'b1;
      end
      rdq_vld_r   <= scan_iss;
      out_valid_r <= cmd.emit;
    end
  end

  // Multiply step: one 17x16 partial product per cycle, top slice first
  assign prod = 33'(p_r) * 33'(tot_sh_r[TW-1 -: 16]);
  assign rsum = {1'b0, acc_r} + (AW + 1)'(16'hFFFF);

  // Running sum with saturation
  assign run_sum = {1'b0, run_r} + (RUN_W + 1)'(rd_cnt);
  assign run_nxt = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];

  assign est_hit  = (rdq_idx_r == '0) ? '0 : est_pow(7'(rdq_idx_r) - 7'd1);
  assign est_dflt = est_pow(7'(BUCKETS - 2));

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r      <= (in_percentile_q16 > Q16_ONE) ? Q16_ONE : in_percentile_q16;
      tot_sh_r <= TW'(total_r);
      acc_r    <= '0;
      mcnt_r   <= MCW'(NCH - 1);
      for (int k = 0; k < NLC; k++) begin
        nz_r[k] <= |in_latency_ns[16*k +: 16];
        lw_r[k] <= lw_nxt[k];
      end
    end
    if (cmd.rec_rd) begin
      bucket_r <= bucket_nxt;
    end
    if (cmd.mul_step) begin
      acc_r    <= (acc_r << 16) + AW'(prod);
      tot_sh_r <= tot_sh_r << 16;
      mcnt_r   <= mcnt_r - 1'b1;
    end
    if (cmd.rank_ld) begin
      rank_r       <= COUNT_WIDTH'(rsum >> 16);
      run_r        <= '0;
      scan_idx_r   <= '0;
      issue_done_r <= 1'b0;
    end
    if (scan_iss) begin
      scan_idx_r   <= scan_idx_r + 1'b1;
      issue_done_r <= (scan_idx_r == LAST_IDX);
      rdq_idx_r    <= scan_idx_r;
    end
    if (rdq_vld_r) begin
      run_r <= run_nxt;
    end
    if (cmd.emit) begin
      out_est_r <= sts.scan_hit ? est_hit : est_dflt;
    end
  end

  // Status back to the controller
  assign sts.mul_last = (mcnt_r == '0);
  assign sts.scan_hit = rdq_vld_r && (run_nxt >= RUN_W'(rank_r));
  assign sts.scan_end = rdq_vld_r && (rdq_idx_r == LAST_IDX);

  assign out_valid            = out_valid_r;
  assign out_latency_estimate = out_est_r;

  `LLH_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held")
  `LLH_ASSERT_SAME(a_wr_after_rd, cmd.rec_wr, $past(cmd.rec_rd), "write without lookup")
  `LLH_ASSERT_SAME(a_emit_cause, cmd.emit, sts.scan_hit || sts.scan_end, "emit without end")

endmodule

@@ sv/llh_ctrl.sv @@
`include "log2_latency_histogram_macros.svh"

module llh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_func,
  output logic          busy,
  output llh_pkg::cmd_t cmd,
  input  llh_pkg::sts_t sts
);
  import llh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REC_RD = 6'b000010,
    S_REC_WR = 6'b000100,
    S_MUL    = 6'b001000,
    S_RANK   = 6'b010000,
    S_SCAN   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_func == FUNC_QUERY) ? S_MUL : S_REC_RD;
        end
      end
      S_REC_RD: begin
        cmd.rec_rd = 1'b1;
        state_nxt  = S_REC_WR;
      end
      S_REC_WR: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = S_RANK;
        end
      end
      S_RANK: begin
        cmd.rank_ld = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_go = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `LLH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not busy")
  `LLH_ASSERT_NEXT(a_emit_idle, cmd.emit, state_r == S_IDLE, "no return to idle after result")
  `LLH_ASSERT_NEXT(a_rank_scan, cmd.rank_ld, cmd.scan_go, "scan did not follow rank")

endmodule

@@ sv/log2_latency_histogram.sv @@
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+-------------------------
// request  | in_func, in_latency_ns, in_percentile_q16          | start && !busy
// result   | out_latency_estimate                               | out_valid, one cycle
//
// One request at a time. A record steps through accept, bucket lookup and counter
// write, and gives no result. A query runs the rank multiply one 16-bit slice a
// cycle, loads the rank, then scans the bucket store one entry a cycle through its
// single registered read port until the rank is reached or the last bucket is read.
// Synchronous active-low reset clears the bucket valid bits, the total and the
// controller. The result strobe lasts one cycle and cannot be stalled.
module log2_latency_histogram #(
  parameter int BUCKETS     = llh_pkg::BUCKETS_DEF,
  parameter int COUNT_WIDTH = llh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [llh_pkg::LAT_W-1:0] in_latency_ns,
  input  logic [llh_pkg::P_W-1:0]   in_percentile_q16,
  output logic                      out_valid,
  output logic [llh_pkg::EST_W-1:0] out_latency_estimate
);
  import llh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  llh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  llh_dp #(
    .BUCKETS     (BUCKETS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_latency_ns        (in_latency_ns),
    .in_percentile_q16    (in_percentile_q16),
    .out_valid            (out_valid),
    .out_latency_estimate (out_latency_estimate)
  );

endmodule
